// ===== rtl/core/alm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Command and status codes and the word types of the linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_DEL     = 2'd1;
  localparam logic [1:0] CMD_DEL_VAL = 2'd2;
  localparam logic [1:0] CMD_ADVANCE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] value;
  } alm_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] cursor_pos;
    logic [6:0] elem_count;
  } alm_rsp_t;

endpackage

// ===== rtl/core/alm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_ram
// Generic RAM with one write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/array_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager_core
// Singly linked list of signed values kept in a link RAM and a value RAM,
// with a free chain, a cursor and an element count.
// ----------------------------------------------------------------------------
// Usage: a command word (req) is taken at a clock edge where start is high
// and busy is low. Its result word (rsp) is shown for exactly one cycle with
// done high; the receiver cannot stall it and must take it in that cycle.
// busy drops in the same cycle that done rises, so the next command may be
// issued while the previous result is shown.
// Entry 0 of the tables heads the list, entry 1 heads the free chain.
// Full and empty errors are answered from the idle state; a delete by value
// walks the list from the head and takes out the first element that matches.
// Every step is one access to the link RAM (one read port and one write port
// used per cycle); the search visits one element per cycle because the link
// and value RAMs are read in parallel.
// After reset the block rebuilds the free chain in the link RAM, with busy
// high; then the list is empty and the cursor is at the head. The value RAM
// is not cleared.
// ----------------------------------------------------------------------------
module array_linked_list_manager_core
  import alm_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  alm_req_t req,
  output logic     done,
  output alm_rsp_t rsp
);

  localparam int TBL = CAPACITY + 2;
  localparam int IW  = $clog2(TBL);
  localparam int CW  = $clog2(CAPACITY + 1);

  localparam logic [IW-1:0] LIST_HEAD = '0;
  localparam logic [IW-1:0] FREE_HEAD = IW'(1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TBL - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADD_E = 4'd2;
  localparam logic [3:0] S_ADD_F = 4'd3;
  localparam logic [3:0] S_ADD_C = 4'd4;
  localparam logic [3:0] S_ADD_L = 4'd5;
  localparam logic [3:0] S_DEL_N = 4'd6;
  localparam logic [3:0] S_DEL_T = 4'd7;
  localparam logic [3:0] S_FR_TN = 4'd8;
  localparam logic [3:0] S_FR_F  = 4'd9;
  localparam logic [3:0] S_FR_H  = 4'd10;
  localparam logic [3:0] S_DV_N  = 4'd11;
  localparam logic [3:0] S_DV_V  = 4'd12;
  localparam logic [3:0] S_ADV   = 4'd13;

  logic [3:0]    state, state_next;
  logic [IW-1:0] cursor, cursor_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] p, p_next;
  logic [IW-1:0] t, t_next;
  logic [IW-1:0] init_idx;
  logic [31:0]   val;
  logic          done_next;
  logic [1:0]    status_next;
  alm_rsp_t      rsp_next;

  logic          lk_we;
  logic [IW-1:0] lk_waddr, lk_wdata, rd_addr, link_rd;
  logic          vl_we;
  logic [31:0]   value_rd;

  logic accept;
  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  alm_ram #(.WIDTH(IW), .DEPTH(TBL)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  // The value RAM is read at the same address as the link RAM.
  alm_ram #(.WIDTH(32), .DEPTH(TBL)) u_value_ram (
    .clk   (clk),
    .we    (vl_we),
    .waddr (t),
    .wdata (val),
    .raddr (rd_addr),
    .rdata (value_rd)
  );

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    count_next  = count;
    p_next      = p;
    t_next      = t;
    done_next   = 1'b0;
    status_next = ST_OK;
    lk_we       = 1'b0;
    lk_waddr    = p;
    lk_wdata    = link_rd;
    rd_addr     = cursor;
    vl_we       = 1'b0;

    unique case (state)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = init_idx;
        if (init_idx == LIST_HEAD) begin
          lk_wdata = LIST_HEAD;
        end else if (init_idx == LAST_IDX) begin
          lk_wdata = FREE_HEAD;
        end else begin
          lk_wdata = init_idx + IW'(1);
        end
        if (init_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req.cmd)
            CMD_ADD: begin
              rd_addr = FREE_HEAD;
              if (count == FULL_CNT) begin
                status_next = ST_FULL;
                done_next   = 1'b1;
              end else begin
                state_next = S_ADD_E;
              end
            end
            CMD_DEL: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                state_next = S_DEL_N;
              end
            end
            CMD_DEL_VAL: begin
              rd_addr = LIST_HEAD;
              p_next  = LIST_HEAD;
              if (count == '0) begin
                status_next = ST_EMPTY;
                done_next   = 1'b1;
              end else begin
                state_next = S_DV_N;
              end
            end
            CMD_ADVANCE: begin
              state_next = S_ADV;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_E: begin
        // link_rd is the first free entry; fetch its successor.
        t_next  = link_rd;
        rd_addr = link_rd;
        state_next = S_ADD_F;
      end
      S_ADD_F: begin
        lk_we      = 1'b1;
        lk_waddr   = FREE_HEAD;
        rd_addr    = cursor;
        state_next = S_ADD_C;
      end
      S_ADD_C: begin
        lk_we      = 1'b1;
        lk_waddr   = t;
        vl_we      = 1'b1;
        state_next = S_ADD_L;
      end
      S_ADD_L: begin
        lk_we      = 1'b1;
        lk_waddr   = cursor;
        lk_wdata   = t;
        count_next = count + CW'(1);
        done_next  = 1'b1;
      end
      S_DEL_N: begin
        // At the end of the list the cursor wraps to the head first.
        rd_addr = link_rd;
        if (link_rd == LIST_HEAD) begin
          cursor_next = LIST_HEAD;
          p_next      = LIST_HEAD;
          state_next  = S_DEL_T;
        end else begin
          p_next     = cursor;
          t_next     = link_rd;
          state_next = S_FR_TN;
        end
      end
      S_DEL_T: begin
        t_next     = link_rd;
        rd_addr    = link_rd;
        state_next = S_FR_TN;
      end
      S_FR_TN: begin
        lk_we      = 1'b1;
        rd_addr    = FREE_HEAD;
        state_next = S_FR_F;
      end
      S_FR_F: begin
        lk_we      = 1'b1;
        lk_waddr   = t;
        state_next = S_FR_H;
      end
      S_FR_H: begin
        lk_we      = 1'b1;
        lk_waddr   = FREE_HEAD;
        lk_wdata   = t;
        if (t == cursor) begin
          cursor_next = LIST_HEAD;
        end
        count_next = count - CW'(1);
        done_next  = 1'b1;
      end
      S_DV_N: begin
        rd_addr = link_rd;
        t_next  = link_rd;
        if (link_rd == LIST_HEAD) begin
          status_next = ST_ABSENT;
          done_next   = 1'b1;
        end else begin
          state_next = S_DV_V;
        end
      end
      S_DV_V: begin
        // value_rd belongs to entry t, link_rd is the entry after t.
        if (value_rd == val) begin
          lk_we      = 1'b1;
          rd_addr    = FREE_HEAD;
          state_next = S_FR_F;
        end else if (link_rd == LIST_HEAD) begin
          status_next = ST_ABSENT;
          done_next   = 1'b1;
        end else begin
          p_next  = t;
          t_next  = link_rd;
          rd_addr = link_rd;
        end
      end
      S_ADV: begin
        cursor_next = link_rd;
        done_next   = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done_next) begin
      state_next = S_IDLE;
    end
    rsp_next.status     = status_next;
    rsp_next.cursor_pos = 7'(cursor_next);
    rsp_next.elem_count = 7'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_idx <= '0;
      cursor   <= LIST_HEAD;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      count  <= count_next;
      done   <= done_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    t <= t_next;
    if (accept) begin
      val <= req.value;
    end
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== test/array_linked_list_manager_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager_core_test
// Self-checking bench for the linked list manager. A scoreboard keeps its own
// copy of the link and value tables, the cursor and the count, predicts the
// result word of every accepted command and checks each result word against
// it. A short directed run covers the corner cases. Random phases that fill,
// drain or mix the list then follow, with random and burst command timing.
// ----------------------------------------------------------------------------
module array_linked_list_manager_core_test;
  import alm_pkg::*;

  localparam int LIST_CAP     = 64;
  localparam int LIST_TBL     = LIST_CAP + 2;
  localparam int RANDOM_WORDS = 1250;
  localparam int STALL_LIMIT  = 2000;

  typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  class list_scoreboard;
    localparam logic [6:0] LIST_HEAD = 7'd0;
    localparam logic [6:0] FREE_HEAD = 7'd1;

    logic [6:0]         link_tbl [LIST_TBL];
    logic signed [31:0] val_tbl  [LIST_TBL];
    logic [6:0]         cur_entry;
    logic [6:0]         n_elems;
    alm_rsp_t           expected_q [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        peak_elems;
    int unsigned        cmd_seen [4];
    int unsigned        status_seen [4];

    function new();
      link_tbl[LIST_HEAD] = LIST_HEAD;
      for (int k = 1; k <= LIST_CAP; k++) begin
        link_tbl[k] = 7'(k + 1);
      end
      link_tbl[LIST_CAP + 1] = FREE_HEAD;
      foreach (val_tbl[k]) val_tbl[k] = '0;
      cur_entry  = LIST_HEAD;
      n_elems    = '0;
      errors     = 0;
      checked    = 0;
      peak_elems = 0;
      foreach (cmd_seen[k]) cmd_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // Moves the entry after p onto the free chain.
    function void release_after(logic [6:0] p);
      logic [6:0] t;
      t = link_tbl[p];
      link_tbl[p] = link_tbl[t];
      link_tbl[t] = link_tbl[FREE_HEAD];
      link_tbl[FREE_HEAD] = t;
      if (t == cur_entry) cur_entry = LIST_HEAD;
      if (n_elems != 0) n_elems--;
    endfunction

    function void note_word(alm_req_t w);
      logic [6:0] e;
      logic [6:0] i;
      logic [6:0] n;
      int         steps;
      bit         found;
      logic [1:0] st;
      alm_rsp_t   want;
      st = ST_OK;
      cmd_seen[w.cmd]++;
      case (w.cmd)
        CMD_ADD: begin
          e = link_tbl[FREE_HEAD];
          if (e == FREE_HEAD || e < 2) begin
            st = ST_FULL;
          end else begin
            link_tbl[FREE_HEAD] = link_tbl[e];
            link_tbl[e] = link_tbl[cur_entry];
            link_tbl[cur_entry] = e;
            val_tbl[e] = w.value;
            n_elems++;
          end
        end
        CMD_DEL: begin
          if (link_tbl[LIST_HEAD] == LIST_HEAD) begin
            st = ST_EMPTY;
          end else begin
            // With the cursor on the last element the delete wraps to the first.
            if (link_tbl[cur_entry] == LIST_HEAD) cur_entry = LIST_HEAD;
            release_after(cur_entry);
          end
        end
        CMD_DEL_VAL: begin
          i = link_tbl[LIST_HEAD];
          if (i == LIST_HEAD) begin
            st = ST_EMPTY;
          end else if (val_tbl[i] == w.value) begin
            release_after(LIST_HEAD);
          end else begin
            steps = 0;
            found = 1'b0;
            while (steps < LIST_TBL) begin
              n = link_tbl[i];
              if (n == LIST_HEAD) break;
              if (val_tbl[n] == w.value) begin
                found = 1'b1;
                break;
              end
              i = n;
              steps++;
            end
            if (found) release_after(i);
            else st = ST_ABSENT;
          end
        end
        default: begin
          cur_entry = link_tbl[cur_entry];
        end
      endcase
      status_seen[st]++;
      if (n_elems > peak_elems) peak_elems = n_elems;
      want.status     = st;
      want.cursor_pos = cur_entry;
      want.elem_count = n_elems;
      expected_q.push_back(want);
    endfunction

    function void check_word(alm_rsp_t got);
      alm_rsp_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending: status %0d cursor %0d count %0d",
                 $time, got.status, got.cursor_pos, got.elem_count);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.cursor_pos !== want.cursor_pos) begin
        $display("%0t: cursor_pos mismatch: expected %0d, actual %0d",
                 $time, want.cursor_pos, got.cursor_pos);
        errors++;
      end
      if (got.elem_count !== want.elem_count) begin
        $display("%0t: elem_count mismatch: expected %0d, actual %0d",
                 $time, want.elem_count, got.elem_count);
        errors++;
      end
    endfunction

    // Value of a random element on the list, so that searches often hit.
    function logic signed [31:0] pick_value();
      logic [6:0] i;
      int         k;
      if (n_elems == 0) return $urandom;
      k = $urandom_range(0, n_elems - 1);
      i = link_tbl[LIST_HEAD];
      repeat (k) i = link_tbl[i];
      return val_tbl[i];
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  alm_req_t req;
  logic     done;
  alm_rsp_t rsp;

  list_scoreboard book;
  bit             burst_mode;
  int unsigned    idle_cycles;

  array_linked_list_manager_core #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result words are checked and idle cycles counted at every rising edge.
  always @(posedge clk) begin
    if (!rst && done) book.check_word(rsp);
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] v);
    int unsigned gap;
    alm_req_t    w;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    w.cmd   = op;
    w.value = v;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req   <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_word(w);
  endtask

  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3, 4, 5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned        n_random;
    int unsigned        plen;
    int unsigned        r;
    phase_t             phase;
    logic [1:0]         op;
    logic signed [31:0] v;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    burst_mode  = 1'b0;
    idle_cycles = 0;
    n_random    = 0;
    book        = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Corner cases on an empty list first, then extremes of the value field,
    // walking the cursor off the end, wrap of delete, and deleting the
    // element that the cursor sits on.
    send_word(CMD_ADVANCE, 32'sd0);
    send_word(CMD_DEL, 32'sd0);
    send_word(CMD_DEL_VAL, 32'sd0);
    send_word(CMD_ADD, 32'sh8000_0000);
    send_word(CMD_ADD, 32'sh7FFF_FFFF);
    send_word(CMD_ADD, 32'sd0);
    send_word(CMD_ADD, -32'sd1);
    repeat (4) send_word(CMD_ADVANCE, 32'sd0);
    send_word(CMD_DEL, 32'sd0);
    send_word(CMD_DEL_VAL, 32'sd12345);
    send_word(CMD_DEL_VAL, 32'sh8000_0000);
    send_word(CMD_ADVANCE, 32'sd0);
    send_word(CMD_DEL_VAL, 32'sd0);
    send_word(CMD_DEL_VAL, 32'sh7FFF_FFFF);
    send_word(CMD_ADD, 32'sh5555_5555);
    send_word(CMD_ADD, 32'shAAAA_AAAA);
    send_word(CMD_ADVANCE, 32'sd0);
    send_word(CMD_DEL, 32'sd0);
    send_word(CMD_ADVANCE, 32'sd0);
    send_word(CMD_ADVANCE, 32'sd0);

    // Fill phases drive the list toward full, drain phases toward empty.
    while (n_random < RANDOM_WORDS) begin
      phase      = phase_t'($urandom_range(0, 2));
      plen       = $urandom_range(30, 150);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (plen) begin
        r = $urandom_range(0, 99);
        case (phase)
          PH_FILL: op = (r < 78) ? CMD_ADD : (r < 85) ? CMD_DEL :
                        (r < 92) ? CMD_DEL_VAL : CMD_ADVANCE;
          PH_DRAIN: op = (r < 15) ? CMD_ADD : (r < 50) ? CMD_DEL :
                         (r < 85) ? CMD_DEL_VAL : CMD_ADVANCE;
          default: op = (r < 30) ? CMD_ADD : (r < 50) ? CMD_DEL :
                        (r < 75) ? CMD_DEL_VAL : CMD_ADVANCE;
        endcase
        if (op == CMD_DEL_VAL && $urandom_range(0, 9) < 6) v = book.pick_value();
        else v = draw_value();
        send_word(op, v);
        n_random++;
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (LIST_CAP + 10) @(posedge clk);

    $display("Commands: add %0d, delete %0d, delete by value %0d, advance %0d; %0d results checked.",
             book.cmd_seen[CMD_ADD], book.cmd_seen[CMD_DEL], book.cmd_seen[CMD_DEL_VAL],
             book.cmd_seen[CMD_ADVANCE], book.checked);
    $display("Status ok %0d, full %0d, empty %0d, absent %0d; largest list %0d elements.",
             book.status_seen[ST_OK], book.status_seen[ST_FULL],
             book.status_seen[ST_EMPTY], book.status_seen[ST_ABSENT], book.peak_elems);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
